### rtl/core/dam_pkg.sv
// Shared types, codes and digit helpers for the decimal add/multiply unit.
`timescale 1ns / 1ps
package dam_pkg;
  localparam int DIGITS = 16;
  localparam int DATA_W = 64;
  localparam int NGRP = (DIGITS + 3) / 4;
  localparam int LVLS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ADD = 2'd0;
  localparam action_t ACT_MUL = 2'd1;
  localparam action_t ACT_CMP = 2'd2;

  typedef struct packed {
    action_t action;
    logic [DATA_W-1:0] a_digits;
    logic [DATA_W-1:0] b_digits;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_digits;
    logic is_equal;
  } rsp_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } ld_t;

  typedef logic [4:0] rdig_t;
  typedef rdig_t [DIGITS-1:0] row_t;
  typedef logic [8:0] col_t;
  typedef col_t [DIGITS-1:0] cols_t;

  // x / 10 by reciprocal, exact for x < 1029
  function automatic logic [5:0] div10(input logic [8:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[16:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [8:0] x, input logic [5:0] q);
    logic [9:0] t;
    t = 10'(x) - 10'(q) * 10'd10;
    return t[3:0];
  endfunction
endpackage

### rtl/core/dam_lane.sv
// One multiplier lane: multiplicand times one digit, carries split out, registered.
`timescale 1ns / 1ps
module dam_lane (
  input  logic clk,
  input  logic en,
  input  logic [dam_pkg::DATA_W-1:0] a_digits,
  input  logic [3:0] d,
  output dam_pkg::row_t row
);
  import dam_pkg::*;

  logic [8:0] prod [DIGITS];
  logic [5:0] hi [DIGITS];
  logic [3:0] lo [DIGITS];
  row_t row_next;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      prod[k] = 9'(a_digits[4*k +: 4]) * 9'(d);
      hi[k] = div10(prod[k]);
      lo[k] = mod10(prod[k], hi[k]);
    end
    for (int k = 0; k < DIGITS; k++) begin
      if (k > 0) begin
        row_next[k] = 5'(lo[k]) + hi[k-1][4:0];
      end else begin
        row_next[k] = 5'(lo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row <= row_next;
    end
  end
endmodule

### rtl/core/dam_merge.sv
// Merge stage: shifted lane rows summed per column in a two-level registered tree.
`timescale 1ns / 1ps
module dam_merge (
  input  logic clk,
  input  dam_pkg::ld_t ld,
  input  dam_pkg::row_t rows [dam_pkg::DIGITS],
  input  dam_pkg::action_t act,
  input  dam_pkg::row_t addc,
  output dam_pkg::cols_t cols
);
  import dam_pkg::*;

  logic [6:0] grp [NGRP][DIGITS];
  logic [6:0] grp_next [NGRP][DIGITS];
  action_t act2;
  row_t addc2;
  cols_t cols_next;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      for (int k = 0; k < DIGITS; k++) begin
        grp_next[g][k] = 7'd0;
        for (int m = 0; m < 4; m++) begin
          if (4*g + m < DIGITS && k >= 4*g + m) begin
            grp_next[g][k] = grp_next[g][k] + 7'(rows[4*g+m][k-4*g-m]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      cols_next[k] = 9'd0;
      if (act2 == ACT_ADD) begin
        cols_next[k] = 9'(addc2[k]);
      end else if (act2 == ACT_MUL) begin
        for (int g = 0; g < NGRP; g++) begin
          cols_next[k] = cols_next[k] + 9'(grp[g][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load_a) begin
      grp <= grp_next;
      act2 <= act;
      addc2 <= addc;
    end
    if (ld.load_b) begin
      cols <= cols_next;
    end
  end
endmodule

### rtl/core/dam_norm.sv
// Decimal carry normalization: three carry rounds, then a lookahead for the last unit carry.
`timescale 1ns / 1ps
module dam_norm (
  input  logic clk,
  input  dam_pkg::ld_t ld,
  input  dam_pkg::cols_t cols,
  output logic [dam_pkg::DATA_W-1:0] digits
);
  import dam_pkg::*;

  logic [5:0] r1 [DIGITS];
  logic [5:0] r1_next [DIGITS];
  logic [3:0] r3 [DIGITS];
  logic [3:0] r3_next [DIGITS];
  logic [5:0] q1 [DIGITS];
  logic [3:0] m1 [DIGITS];
  logic [5:0] q2 [DIGITS];
  logic [3:0] m2 [DIGITS];
  logic [4:0] t2 [DIGITS];
  logic [5:0] q3 [DIGITS];
  logic [3:0] m3 [DIGITS];
  logic gen [LVLS+1][DIGITS];
  logic prp [LVLS+1][DIGITS];
  logic cin;
  logic [4:0] s;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      q1[k] = div10(cols[k]);
      m1[k] = mod10(cols[k], q1[k]);
    end
    for (int k = 0; k < DIGITS; k++) begin
      r1_next[k] = (k > 0) ? 6'(m1[k]) + q1[k-1] : 6'(m1[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      q2[k] = div10(9'(r1[k]));
      m2[k] = mod10(9'(r1[k]), q2[k]);
    end
    for (int k = 0; k < DIGITS; k++) begin
      t2[k] = (k > 0) ? 5'(m2[k]) + q2[k-1][4:0] : 5'(m2[k]);
    end
    for (int k = 0; k < DIGITS; k++) begin
      q3[k] = div10(9'(t2[k]));
      m3[k] = mod10(9'(t2[k]), q3[k]);
    end
    for (int k = 0; k < DIGITS; k++) begin
      r3_next[k] = (k > 0) ? m3[k] + q3[k-1][3:0] : m3[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load_a) begin
      r1 <= r1_next;
    end
    if (ld.load_b) begin
      r3 <= r3_next;
    end
  end

  // digits are 0..10 here; a ten generates, a nine propagates
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      gen[0][k] = (r3[k] == 4'd10);
      prp[0][k] = (r3[k] == 4'd9);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int k = 0; k < DIGITS; k++) begin
        if (k >= (1 << l)) begin
          gen[l+1][k] = gen[l][k] | (prp[l][k] & gen[l][k - (1 << l)]);
          prp[l+1][k] = prp[l][k] & prp[l][k - (1 << l)];
        end else begin
          gen[l+1][k] = gen[l][k];
          prp[l+1][k] = prp[l][k];
        end
      end
    end
    digits = '0;
    for (int k = 0; k < DIGITS; k++) begin
      cin = (k > 0) ? gen[LVLS][k-1] : 1'b0;
      s = 5'(r3[k]) + 5'(cin);
      digits[4*k +: 4] = (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
    end
  end
endmodule

### rtl/core/decimal_add_multiply_unit.sv
// Top level: fixed-width BCD add, schoolbook multiply and digit compare.
// Pipeline from input transfer to result valid: lanes load at the transfer
// edge, then two merge levels, two carry stages, output register.
// Throughput: one transfer per cycle unless stalled; each stage holds when its successor stalls.
// Reset clears the stage valid flags and the output valid; payload is not reset.
`timescale 1ns / 1ps
module decimal_add_multiply_unit (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  dam_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output dam_pkg::rsp_t rsp
);
  import dam_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] v;
  logic [NSTG:0] en;
  logic [NSTG-1:0] eq;
  logic eq_next;
  action_t act1;
  row_t addc1;
  row_t addc_next;
  row_t rows [DIGITS];
  cols_t cols;
  logic [DATA_W-1:0] digits;
  logic [DATA_W-1:0] dig_mask;

  always_comb begin
    en[NSTG] = !rsp_valid || !rsp_stall;
    for (int s = NSTG - 1; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign req_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (en[0]) begin
        v[0] <= req_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
      if (en[NSTG]) begin
        rsp_valid <= v[NSTG-1];
      end
    end
  end

  always_comb begin
    dig_mask = '0;
    for (int k = 0; k < DIGITS; k++) begin
      dig_mask[4*k +: 4] = 4'hf;
      addc_next[k] = 5'(req.a_digits[4*k +: 4]) + 5'(req.b_digits[4*k +: 4]);
    end
    eq_next = (req.action == ACT_CMP) && (((req.a_digits ^ req.b_digits) & dig_mask) == '0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      act1 <= req.action;
      addc1 <= addc_next;
      eq[0] <= eq_next;
    end
    for (int s = 1; s < NSTG; s++) begin
      if (en[s]) begin
        eq[s] <= eq[s-1];
      end
    end
    if (en[NSTG]) begin
      rsp.result_digits <= digits;
      rsp.is_equal <= eq[NSTG-1];
    end
  end

  for (genvar i = 0; i < DIGITS; i++) begin : g_lane
    dam_lane u_lane (
      .clk(clk),
      .en(en[0]),
      .a_digits(req.a_digits),
      .d(req.b_digits[4*i +: 4]),
      .row(rows[i])
    );
  end

  dam_merge u_merge (
    .clk(clk),
    .ld('{load_a: en[1], load_b: en[2]}),
    .rows(rows),
    .act(act1),
    .addc(addc1),
    .cols(cols)
  );

  dam_norm u_norm (
    .clk(clk),
    .ld('{load_a: en[3], load_b: en[4]}),
    .cols(cols),
    .digits(digits)
  );
endmodule
